[sv/ps2_host_frame_engine_assert.svh]
// Assertion macros used by the PS/2 host frame engine core.
`ifndef PS2_HOST_FRAME_ENGINE_ASSERT_SVH
`define PS2_HOST_FRAME_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PS2HFE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define PS2HFE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ps2hfe_pkg.sv]
// Types, codes, constants and helper functions of the PS/2 host frame engine.
package ps2hfe_pkg;

  localparam int BIT_POS_W = 4;
  localparam int FRAME_W   = 10;

  localparam logic [BIT_POS_W-1:0] POS_PARITY    = 4'd8;
  localparam logic [BIT_POS_W-1:0] POS_STOP      = 4'd9;
  localparam logic [BIT_POS_W-1:0] POS_LAST_BIT  = 4'd10;
  localparam logic [BIT_POS_W-1:0] POS_FRAME_END = 4'd11;

  localparam logic REQ_EDGE  = 1'b0;
  localparam logic REQ_SEND  = 1'b1;
  localparam logic EDGE_FALL = 1'b0;
  localparam logic EDGE_RISE = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic       edge_rising;
    logic       data_level;
    logic [7:0] send_byte;
  } item_t;

  typedef struct packed {
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       tx_done;
    logic       tx_acked;
    logic       drive_value;
    logic       drive_enable;
    logic       clock_inhibit_pulse;
    logic       link_busy;
  } result_t;

  // Odd parity bit: high when the byte holds an even number of ones.
  function automatic logic odd_parity(input logic [7:0] b);
    return ~(^b);
  endfunction

endpackage

[sv/ps2hfe_if.sv]
// Valid/ready channel interfaces for the event input and the result output.
interface ps2hfe_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic       edge_rising;
  logic       data_level;
  logic [7:0] send_byte;

  modport source (output valid, req_type, edge_rising, data_level, send_byte,
                  input ready);
  modport sink   (input valid, req_type, edge_rising, data_level, send_byte,
                  output ready);
endinterface

interface ps2hfe_out_if;
  logic       valid;
  logic       ready;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       tx_done;
  logic       tx_acked;
  logic       drive_value;
  logic       drive_enable;
  logic       clock_inhibit_pulse;
  logic       link_busy;

  modport source (output valid, rx_valid, rx_byte, tx_done, tx_acked, drive_value,
                  drive_enable, clock_inhibit_pulse, link_busy,
                  input ready);
  modport sink   (input valid, rx_valid, rx_byte, tx_done, tx_acked, drive_value,
                  drive_enable, clock_inhibit_pulse, link_busy,
                  output ready);
endinterface

[sv/ps2_host_frame_engine.sv]
// PS/2 host frame engine top level: input register, frame core, result register.
// An event beat taken into the input register passes through the core logic into the result register.
// Throughput: one event beat per cycle unless out_ch stalls, set by the core's single update.
// An unaccepted result holds in the result register while the input register takes
// one more beat; rst_n (synchronous, active low) empties both registers at once.
// Reset clears the frame state: both directions idle, data line released high.
module ps2_host_frame_engine
  import ps2hfe_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  ps2hfe_in_if.sink    in_ch,
  ps2hfe_out_if.source out_ch
);

  // The input register holds the next event; step_en moves it through the core
  // into the result register whenever that register is empty or being drained.
  logic    item_valid;
  item_t   item;
  logic    step_en;
  result_t res;

  ps2hfe_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .pop        (step_en),
    .item_valid (item_valid),
    .item       (item)
  );

  // All receive and transmit state lives in the core and advances once per beat.
  ps2hfe_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (item),
    .res     (res)
  );

  // Exactly one result beat leaves for every event beat that enters.
  ps2hfe_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .res        (res),
    .step_en    (step_en),
    .out_ch     (out_ch)
  );

endmodule

[sv/ps2hfe_in_stage.sv]
// Input register: captures one event beat and holds it until the core takes it.
module ps2hfe_in_stage
  import ps2hfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ps2hfe_in_if.sink   in_ch,
  input  logic        pop,
  output logic        item_valid,
  output item_t       item
);

  logic  valid_r;
  item_t item_r;

  assign in_ch.ready = !valid_r || pop;
  assign item_valid  = valid_r;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      valid_r <= 1'b1;
    end else if (pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.req_type    <= in_ch.req_type;
      item_r.edge_rising <= in_ch.edge_rising;
      item_r.data_level  <= in_ch.data_level;
      item_r.send_byte   <= in_ch.send_byte;
    end
  end

endmodule

[sv/ps2hfe_core.sv]
// Frame state and per-event next-state logic for receive and transmit frames.
`include "ps2_host_frame_engine_assert.svh"

module ps2hfe_core
  import ps2hfe_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  item_t   item,
  output result_t res
);

  logic                 tx_active_r,      tx_active_nxt;
  logic                 tx_first_edge_r,  tx_first_edge_nxt;
  logic                 tx_ack_seen_r,    tx_ack_seen_nxt;
  logic [7:0]           tx_shift_byte_r,  tx_shift_byte_nxt;
  logic                 rx_active_r,      rx_active_nxt;
  logic [BIT_POS_W-1:0] bit_pos_r,        bit_pos_nxt;
  logic [FRAME_W-1:0]   rx_frame_r,       rx_frame_nxt;
  logic                 drive_level_r,    drive_level_nxt;
  logic                 drive_on_r,       drive_on_nxt;
  logic [BIT_POS_W-1:0] bit_pos_inc;
  logic [BIT_POS_W-1:0] rx_idx;

  assign bit_pos_inc = bit_pos_r + 1'b1;
  assign rx_idx      = bit_pos_r - 1'b1;

  always_comb begin
    tx_active_nxt     = tx_active_r;
    tx_first_edge_nxt = tx_first_edge_r;
    tx_ack_seen_nxt   = tx_ack_seen_r;
    tx_shift_byte_nxt = tx_shift_byte_r;
    rx_active_nxt     = rx_active_r;
    bit_pos_nxt       = bit_pos_r;
    rx_frame_nxt      = rx_frame_r;
    drive_level_nxt   = drive_level_r;
    drive_on_nxt      = drive_on_r;
    res               = '0;

    if (item.req_type == REQ_SEND) begin
      // A send request always (re)starts a transmission and abandons a receive.
      tx_active_nxt           = 1'b1;
      tx_first_edge_nxt       = 1'b1;
      tx_ack_seen_nxt         = 1'b0;
      tx_shift_byte_nxt       = item.send_byte;
      bit_pos_nxt             = '0;
      rx_active_nxt           = 1'b0;
      drive_level_nxt         = 1'b0;
      drive_on_nxt            = 1'b1;
      res.clock_inhibit_pulse = 1'b1;
    end else if (tx_active_r) begin
      if (item.edge_rising == EDGE_FALL) begin
        if (tx_first_edge_r) begin
          tx_first_edge_nxt = 1'b0;
          tx_ack_seen_nxt   = 1'b0;
          bit_pos_nxt       = '0;
        end
        if (bit_pos_nxt == POS_FRAME_END) begin
          tx_ack_seen_nxt = ~item.data_level;
        end
      end else if (!tx_first_edge_r) begin
        if (bit_pos_r < POS_PARITY) begin
          drive_level_nxt = tx_shift_byte_r[bit_pos_r[2:0]];
          bit_pos_nxt     = bit_pos_inc;
        end else if (bit_pos_r == POS_PARITY) begin
          drive_level_nxt = odd_parity(tx_shift_byte_r);
          bit_pos_nxt     = bit_pos_inc;
        end else if (bit_pos_r == POS_STOP) begin
          drive_level_nxt = 1'b1;
          drive_on_nxt    = 1'b0;
          bit_pos_nxt     = bit_pos_inc;
        end else if (bit_pos_r == POS_FRAME_END) begin
          res.tx_done   = 1'b1;
          res.tx_acked  = tx_ack_seen_r;
          tx_active_nxt = 1'b0;
          bit_pos_nxt   = '0;
        end else begin
          bit_pos_nxt = bit_pos_inc;
        end
      end
    end else begin
      if (item.edge_rising == EDGE_FALL) begin
        if (!rx_active_r) begin
          if (!item.data_level) begin
            rx_frame_nxt  = '0;
            rx_active_nxt = 1'b1;
            bit_pos_nxt   = '0;
          end
        end else if (bit_pos_r >= 4'd1 && bit_pos_r <= POS_LAST_BIT) begin
          rx_frame_nxt[rx_idx] = item.data_level;
        end
      end else if (rx_active_r) begin
        bit_pos_nxt = bit_pos_inc;
        if (bit_pos_inc >= POS_FRAME_END) begin
          rx_active_nxt = 1'b0;
          bit_pos_nxt   = '0;
          if (rx_frame_r[8] == odd_parity(rx_frame_r[7:0]) && rx_frame_r[FRAME_W-1]) begin
            res.rx_valid = 1'b1;
            res.rx_byte  = rx_frame_r[7:0];
          end
        end
      end
    end

    res.drive_value  = drive_level_nxt;
    res.drive_enable = drive_on_nxt;
    res.link_busy    = tx_active_nxt | rx_active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_active_r     <= 1'b0;
      tx_first_edge_r <= 1'b0;
      tx_ack_seen_r   <= 1'b0;
      tx_shift_byte_r <= '0;
      rx_active_r     <= 1'b0;
      bit_pos_r       <= '0;
      rx_frame_r      <= '0;
      drive_level_r   <= 1'b1;
      drive_on_r      <= 1'b0;
    end else if (step_en) begin
      tx_active_r     <= tx_active_nxt;
      tx_first_edge_r <= tx_first_edge_nxt;
      tx_ack_seen_r   <= tx_ack_seen_nxt;
      tx_shift_byte_r <= tx_shift_byte_nxt;
      rx_active_r     <= rx_active_nxt;
      bit_pos_r       <= bit_pos_nxt;
      rx_frame_r      <= rx_frame_nxt;
      drive_level_r   <= drive_level_nxt;
      drive_on_r      <= drive_on_nxt;
    end
  end

  `PS2HFE_ASSERT_IMP(a_one_direction, 1'b1, !(tx_active_r && rx_active_r),
                     "rx and tx both active")
  `PS2HFE_ASSERT_IMP(a_bit_pos_range, 1'b1, bit_pos_r <= POS_FRAME_END,
                     "bit position past frame end")
  `PS2HFE_ASSERT_NXT(a_send_starts, step_en && item.req_type == REQ_SEND,
                     tx_active_r && drive_on_r && !rx_active_r,
                     "send did not start transmit")
  `PS2HFE_ASSERT_IMP(a_done_excl, step_en && res.tx_done,
                     !res.rx_valid && !res.link_busy,
                     "tx done with rx result or busy")

endmodule

[sv/ps2hfe_out_stage.sv]
// Result register: holds one result beat and decides when the core may step.
module ps2hfe_out_stage
  import ps2hfe_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         item_valid,
  input  result_t      res,
  output logic         step_en,
  ps2hfe_out_if.source out_ch
);

  logic    valid_r;
  result_t res_r;

  assign step_en = item_valid && (!valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (step_en) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res;
    end
  end

  assign out_ch.valid               = valid_r;
  assign out_ch.rx_valid            = res_r.rx_valid;
  assign out_ch.rx_byte             = res_r.rx_byte;
  assign out_ch.tx_done             = res_r.tx_done;
  assign out_ch.tx_acked            = res_r.tx_acked;
  assign out_ch.drive_value         = res_r.drive_value;
  assign out_ch.drive_enable        = res_r.drive_enable;
  assign out_ch.clock_inhibit_pulse = res_r.clock_inhibit_pulse;
  assign out_ch.link_busy           = res_r.link_busy;

endmodule

[test/ps2hfe_frame_checker.sv]
// Checker for the PS/2 host frame engine: predicts every result beat and compares it.
module ps2hfe_frame_checker
  import ps2hfe_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  ps2hfe_in_if  in_ch,
  ps2hfe_out_if out_ch,
  output int    mismatches,
  output int    awaited
);

  // Predicted link state.
  logic       tx_on;
  logic       tx_await_fall;
  logic       ack_low;
  logic [7:0] tx_byte;
  logic       rx_on;
  logic [4:0] bit_pos;
  logic [9:0] rx_bits;
  logic       line_level;
  logic       line_driven;

  result_t due_q[$];

  task automatic clear_link();
    tx_on         = 1'b0;
    tx_await_fall = 1'b0;
    ack_low       = 1'b0;
    tx_byte       = '0;
    rx_on         = 1'b0;
    bit_pos       = '0;
    rx_bits       = '0;
    line_level    = 1'b1;
    line_driven   = 1'b0;
  endtask

  // Applies one event beat to the predicted state and returns the result it causes.
  task automatic advance_link(input item_t ev, output result_t res);
    res = '0;
    if (ev.req_type == REQ_SEND) begin
      // A send request always wins, whatever is in progress.
      tx_on               = 1'b1;
      tx_await_fall       = 1'b1;
      ack_low             = 1'b0;
      tx_byte             = ev.send_byte;
      bit_pos             = '0;
      rx_on               = 1'b0;
      line_level          = 1'b0;
      line_driven         = 1'b1;
      res.clock_inhibit_pulse = 1'b1;
    end else if (tx_on) begin
      if (ev.edge_rising == EDGE_FALL) begin
        if (tx_await_fall) begin
          tx_await_fall = 1'b0;
          ack_low       = 1'b0;
          bit_pos       = '0;
        end
        if (bit_pos == POS_FRAME_END) ack_low = ~ev.data_level;
      end else if (!tx_await_fall) begin
        if (bit_pos < POS_PARITY) begin
          line_level = tx_byte[bit_pos];
          bit_pos++;
        end else if (bit_pos == POS_PARITY) begin
          line_level = ~^tx_byte;
          bit_pos++;
        end else if (bit_pos == POS_STOP) begin
          line_level  = 1'b1;
          line_driven = 1'b0;
          bit_pos++;
        end else if (bit_pos == POS_FRAME_END) begin
          res.tx_done  = 1'b1;
          res.tx_acked = ack_low;
          tx_on        = 1'b0;
          bit_pos      = '0;
        end else begin
          bit_pos++;
        end
      end
    end else if (ev.edge_rising == EDGE_FALL) begin
      if (!rx_on) begin
        if (!ev.data_level) begin
          rx_bits = '0;
          rx_on   = 1'b1;
          bit_pos = '0;
        end
      end else if (bit_pos >= 1 && bit_pos <= POS_LAST_BIT) begin
        rx_bits[bit_pos - 1] = ev.data_level;
      end
    end else if (rx_on) begin
      bit_pos++;
      if (bit_pos >= POS_FRAME_END) begin
        rx_on   = 1'b0;
        bit_pos = '0;
        if (rx_bits[POS_PARITY] == ~^rx_bits[7:0] && rx_bits[POS_STOP]) begin
          res.rx_valid = 1'b1;
          res.rx_byte  = rx_bits[7:0];
        end
      end
    end
    res.drive_value  = line_level;
    res.drive_enable = line_driven;
    res.link_busy    = tx_on | rx_on;
  endtask

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    item_t   ev;
    result_t want;
    if (!rst_n) begin
      clear_link();
      due_q.delete();
      mismatches = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        ev = '{req_type: in_ch.req_type, edge_rising: in_ch.edge_rising,
               data_level: in_ch.data_level, send_byte: in_ch.send_byte};
        advance_link(ev, want);
        due_q.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (due_q.size() == 0) begin
          $error("result beat arrived with nothing expected");
          mismatches++;
        end else begin
          want = due_q.pop_front();
          check_field("rx_valid", 8'(want.rx_valid), 8'(out_ch.rx_valid));
          check_field("rx_byte", want.rx_byte, out_ch.rx_byte);
          check_field("tx_done", 8'(want.tx_done), 8'(out_ch.tx_done));
          check_field("tx_acked", 8'(want.tx_acked), 8'(out_ch.tx_acked));
          check_field("drive_value", 8'(want.drive_value), 8'(out_ch.drive_value));
          check_field("drive_enable", 8'(want.drive_enable), 8'(out_ch.drive_enable));
          check_field("clock_inhibit_pulse", 8'(want.clock_inhibit_pulse),
                      8'(out_ch.clock_inhibit_pulse));
          check_field("link_busy", 8'(want.link_busy), 8'(out_ch.link_busy));
        end
      end
    end
    awaited = due_q.size();
  end

endmodule

[test/ps2_host_frame_engine_tb.sv]
// Testbench top for the PS/2 host frame engine: clock, reset, event stimulus and verdict.
module ps2_host_frame_engine_tb;
  import ps2hfe_pkg::*;

  // Roughly this many event beats are offered after the directed opening.
  localparam int RANDOM_BEATS    = 700;
  // The long receiver hold-off starts once this many beats have gone in.
  localparam int HOLD_OFF_AT     = 300;
  localparam int HOLD_OFF_CYCLES = 120;
  // Beats in this window are offered and taken with no idling on either side.
  localparam int CALM_FROM       = 450;
  localparam int CALM_TO         = 550;
  // Several times the slowest correct run.
  localparam int RUN_LIMIT       = 4000000;
  // Extra wait after the last expected result has been seen, before the verdict.
  localparam int DRAIN_CYCLES    = 8;

  logic clk = 1'b0;
  logic rst_n;

  ps2hfe_in_if  in_ch();
  ps2hfe_out_if out_ch();

  int mismatches;
  int awaited;
  int beats_sent = 0;
  bit calm       = 1'b0;
  bit held_off   = 1'b0;

  // Beats of the sequence currently being built, offered in order by play_frame.
  item_t frame_q[$];

  ps2_host_frame_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ps2hfe_frame_checker frame_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Idle length shared by both sides: mostly none, sometimes a few cycles, rarely long.
  function automatic int idle_length();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Bytes lean towards the extremes now and then so that 8'h00 and 8'hFF turn up often.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // A device clock edge. The send byte is random, as the block must ignore it here.
  function automatic item_t edge_ev(input logic rising, input logic level);
    return '{req_type: REQ_EDGE, edge_rising: rising, data_level: level,
             send_byte: 8'($urandom)};
  endfunction

  // A send request. The edge fields are random, as the block must ignore them here.
  function automatic item_t send_ev(input logic [7:0] b);
    return '{req_type: REQ_SEND, edge_rising: 1'($urandom), data_level: 1'($urandom),
             send_byte: b};
  endfunction

  // A receive frame: start bit, eight data bits LSB first, odd parity and stop, each
  // sampled on a falling edge, then the rising edge that closes the frame. Parity and
  // stop can be corrupted on request so that the block has to drop the frame.
  function automatic void queue_rx_frame(input logic [7:0] b, input bit bad_par,
                                         input bit bad_stop);
    logic [9:0] bits;
    bits = {~bad_stop, (~^b) ^ bad_par, b};
    frame_q.push_back(edge_ev(EDGE_FALL, 1'b0));
    for (int i = 0; i < 10; i++) begin
      frame_q.push_back(edge_ev(EDGE_RISE, 1'($urandom)));
      frame_q.push_back(edge_ev(EDGE_FALL, bits[i]));
    end
    frame_q.push_back(edge_ev(EDGE_RISE, 1'($urandom)));
  endfunction

  // A transmit frame: the request, sometimes a stray rising edge before the device
  // starts clocking, then the first falling edge and pairs of rising and falling edges.
  // The rising edges clock out data, parity and stop and reach the ack slot, whose
  // falling edge carries the device's ack; the last rising edge finishes the frame.
  function automatic void queue_tx_frame(input logic [7:0] b, input bit ack);
    frame_q.push_back(send_ev(b));
    if ($urandom_range(0, 3) == 0) frame_q.push_back(edge_ev(EDGE_RISE, 1'($urandom)));
    frame_q.push_back(edge_ev(EDGE_FALL, 1'($urandom)));
    for (int i = 0; i < 11; i++) begin
      frame_q.push_back(edge_ev(EDGE_RISE, 1'($urandom)));
      frame_q.push_back(edge_ev(EDGE_FALL, (i == 10) ? ~ack : 1'($urandom)));
    end
    frame_q.push_back(edge_ev(EDGE_RISE, 1'($urandom)));
  endfunction

  // Brings the link back to idle from any state: a falling edge with data high starts
  // nothing and ends a pending transmit start, and the rising edges that follow are
  // enough to run any receive or transmit frame out to its end.
  function automatic void queue_flush();
    frame_q.push_back(edge_ev(EDGE_FALL, 1'b1));
    repeat (12) frame_q.push_back(edge_ev(EDGE_RISE, 1'($urandom)));
  endfunction

  // Offers one beat and returns at the edge where it is taken. The valid line is only
  // lowered when an idle gap follows, so it is never dropped and raised in one step.
  task automatic offer(input item_t ev);
    int gap;
    gap = idle_length();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= ev.req_type;
    in_ch.edge_rising <= ev.edge_rising;
    in_ch.data_level  <= ev.data_level;
    in_ch.send_byte   <= ev.send_byte;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
  endtask

  // Offers the first cut beats of the built sequence and throws the rest away.
  task automatic play_frame(input int cut);
    for (int i = 0; i < frame_q.size() && i < cut; i++) offer(frame_q[i]);
    frame_q.delete();
  endtask

  // Event source: reset, a directed opening, then mostly well-formed frames with
  // random content and a minority of broken frames and noise.
  initial begin : event_source
    int kind;
    int random_end;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.req_type    <= REQ_EDGE;
    in_ch.edge_rising <= EDGE_FALL;
    in_ch.data_level  <= 1'b1;
    in_ch.send_byte   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening. A rising edge and a falling edge with data high while idle
    // must both be ignored; then a start bit, followed by a falling edge before any
    // rising edge, which must be ignored as well.
    frame_q.push_back(edge_ev(EDGE_RISE, 1'b0));
    frame_q.push_back(edge_ev(EDGE_FALL, 1'b1));
    frame_q.push_back(edge_ev(EDGE_FALL, 1'b0));
    frame_q.push_back(edge_ev(EDGE_FALL, 1'b1));
    frame_q.push_back(edge_ev(EDGE_RISE, 1'b1));
    // A send request in the middle of reception abandons the receive frame; its edge
    // fields are set high to show they are ignored.
    frame_q.push_back(item_t'{req_type: REQ_SEND, edge_rising: EDGE_RISE,
                              data_level: 1'b1, send_byte: 8'hFF});
    // A rising edge before the device's first falling edge does nothing.
    frame_q.push_back(edge_ev(EDGE_RISE, 1'b0));
    frame_q.push_back(edge_ev(EDGE_FALL, 1'b0));
    frame_q.push_back(edge_ev(EDGE_RISE, 1'b0));
    // A second request while transmitting restarts the transmission.
    frame_q.push_back(item_t'{req_type: REQ_SEND, edge_rising: EDGE_FALL,
                              data_level: 1'b0, send_byte: 8'h00});
    queue_flush();
    play_frame(frame_q.size());

    // Random part.
    random_end = beats_sent + RANDOM_BEATS;
    while (beats_sent < random_end) begin
      calm = (beats_sent >= CALM_FROM && beats_sent < CALM_TO);
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        queue_rx_frame(pick_byte(), 1'b0, 1'b0);
        play_frame(frame_q.size());
      end else if (kind < 70) begin
        queue_tx_frame(pick_byte(), 1'($urandom));
        play_frame(frame_q.size());
      end else if (kind < 80) begin
        // Bad parity, bad stop or both: the frame must vanish without a report.
        case ($urandom_range(0, 2))
          0:       queue_rx_frame(pick_byte(), 1'b1, 1'b0);
          1:       queue_rx_frame(pick_byte(), 1'b0, 1'b1);
          default: queue_rx_frame(pick_byte(), 1'b1, 1'b1);
        endcase
        play_frame(frame_q.size());
      end else if (kind < 87) begin
        // Receive frame broken off part way; the next sequence decides what follows.
        queue_rx_frame(pick_byte(), 1'b0, 1'b0);
        play_frame($urandom_range(1, 20));
        if ($urandom_range(0, 1) == 0) begin
          queue_tx_frame(pick_byte(), 1'($urandom));
          play_frame(frame_q.size());
        end else begin
          queue_flush();
          play_frame(frame_q.size());
        end
      end else if (kind < 93) begin
        // Transmit frame broken off part way, sometimes restarted by a fresh request.
        queue_tx_frame(pick_byte(), 1'($urandom));
        play_frame($urandom_range(1, 24));
        if ($urandom_range(0, 1) == 0) queue_tx_frame(pick_byte(), 1'($urandom));
        else queue_flush();
        play_frame(frame_q.size());
      end else begin
        // Noise: arbitrary events in any state, then a return to idle.
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 7) == 0) frame_q.push_back(send_ev(8'($urandom)));
          else frame_q.push_back(edge_ev(1'($urandom), 1'($urandom)));
        end
        queue_flush();
        play_frame(frame_q.size());
      end
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    // One edge lets the checker log the last beat before its count is trusted.
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (awaited != 0) $error("%0d expected results never arrived", awaited);
    if (mismatches == 0 && awaited == 0) begin
      $display("** ps2_host_frame_engine: PASSED **");
    end else begin
      $display("** ps2_host_frame_engine: FAILED **");
    end
    $finish;
  end

  // Result sink: random stalls, plus one long hold-off while the sender keeps offering
  // beats, so that both registers of the block fill and its input stalls.
  initial begin : result_sink
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!held_off && beats_sent >= HOLD_OFF_AT) begin
        held_off = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      gap = idle_length();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Guard against a hung handshake.
  initial begin : run_limit
    #(RUN_LIMIT);
    $display("** ps2_host_frame_engine: FAILED **");
    $finish;
  end

endmodule
